/* rtl/winograd_f2x2_3x3_tile_conv_assert.svh */
// Assertion helpers for the Winograd tile engine.
`ifndef WINOGRAD_F2X2_3X3_TILE_CONV_ASSERT_SVH
`define WINOGRAD_F2X2_3X3_TILE_CONV_ASSERT_SVH

// Same-cycle implication under active-low reset.
`define WTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under active-low reset.
`define WTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wtc_pkg.sv */
`default_nettype none

package wtc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W    = 48;
    localparam int ROW_W    = 2;

    // Tile geometry
    localparam int TILE_N     = 4;
    localparam int KER_N      = 3;
    localparam int STORE_ROWS = 3;
    localparam int LANES      = TILE_N * TILE_N;
    localparam int OUTS       = 4;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(3);

    // Growth through the transforms (kernel side runs at scale 4)
    localparam int RT_W   = SAMPLE_W + 1;
    localparam int DT_W   = SAMPLE_W + 2;
    localparam int KR_W   = WEIGHT_W + 2;
    localparam int KT_W   = WEIGHT_W + 4;
    localparam int PROD_W = DT_W + KT_W;
    localparam int Y_W    = PROD_W + 2;
    localparam int O_W    = PROD_W + 4;
    localparam int V_W    = O_W - 2;

    // Stream widths
    localparam int S_TDATA_W = ((TILE_N * SAMPLE_W + KER_N * WEIGHT_W + 7) / 8) * 8;
    localparam int S_TUSER_W = ROW_W + 1;
    localparam int M_TDATA_W = ((OUTS * ACC_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [RT_W-1:0]     rt_t;
    typedef logic signed [DT_W-1:0]     dt_t;
    typedef logic signed [KR_W-1:0]     kr_t;
    typedef logic signed [KT_W-1:0]     kt_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [Y_W-1:0]      y_t;
    typedef logic signed [O_W-1:0]      o_t;
    typedef logic signed [V_W-1:0]      v_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Control that travels with a last-row request
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } ctl_t;

    // One emitted result, out00 in the low element
    typedef struct packed {
        acc_t [OUTS-1:0] sums;
        logic            sat;
    } result_t;

endpackage

`default_nettype wire

/* rtl/wtc_lane.sv */
`default_nettype none

module wtc_lane (
    input  wire            aclk,
    input  wire            adv,
    input  wtc_pkg::dt_t   dt,
    input  wtc_pkg::kt_t   kt,
    output wtc_pkg::prod_t prod
);
    import wtc_pkg::*;

    prod_t prod_next;
    prod_t prod_reg;

    // Elementwise product of transformed tile and kernel
    assign prod_next = PROD_W'(dt) * PROD_W'(kt);

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/wtc_merge.sv */
`default_nettype none

module wtc_merge (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              adv,
    input  wtc_pkg::prod_t   prod [wtc_pkg::LANES],
    input  wtc_pkg::ctl_t    ctl_in,
    output logic             push,
    output wtc_pkg::result_t result
);
    import wtc_pkg::*;

    ctl_t ctl3_reg;
    ctl_t ctl4_reg;
    y_t   y_next [2][TILE_N];
    y_t   y_reg  [2][TILE_N];
    o_t   osum   [OUTS];
    v_t   o_next [OUTS];
    v_t   o_reg  [OUTS];
    acc_t acc_reg  [OUTS];
    acc_t acc_next [OUTS];
    logic signed [ACC_W:0] wide_sum [OUTS];
    logic [OUTS-1:0] ovf;
    logic sat_reg;
    logic sat_next;

    // Output transform, first pass: combine product rows
    always_comb begin
        for (int j = 0; j < TILE_N; j++) begin
            y_next[0][j] = Y_W'(prod[j]) + Y_W'(prod[TILE_N + j])
                         + Y_W'(prod[2*TILE_N + j]);
            y_next[1][j] = Y_W'(prod[TILE_N + j]) - Y_W'(prod[2*TILE_N + j])
                         - Y_W'(prod[3*TILE_N + j]);
        end
    end

    // Output transform, second pass: combine columns, drop the scale of 4
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            osum[2*i]     = O_W'(y_reg[i][0]) + O_W'(y_reg[i][1]) + O_W'(y_reg[i][2]);
            osum[2*i + 1] = O_W'(y_reg[i][1]) - O_W'(y_reg[i][2]) - O_W'(y_reg[i][3]);
        end
        for (int k = 0; k < OUTS; k++) begin
            o_next[k] = osum[k][O_W-1:2];
        end
    end

    // Saturating accumulate, cleared on the first channel
    always_comb begin
        for (int k = 0; k < OUTS; k++) begin
            wide_sum[k] = (ctl4_reg.first ? (ACC_W+1)'(0) : (ACC_W+1)'(acc_reg[k]))
                        + (ACC_W+1)'(o_reg[k]);
            ovf[k] = wide_sum[k][ACC_W] ^ wide_sum[k][ACC_W-1];
            if (ovf[k]) begin
                acc_next[k] = wide_sum[k][ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                acc_next[k] = wide_sum[k][ACC_W-1:0];
            end
        end
        sat_next = (ctl4_reg.first ? 1'b0 : sat_reg) | (|ovf);
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= y_next;
            o_reg <= o_next;
        end
    end

    // Control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            sat_reg  <= 1'b0;
            for (int k = 0; k < OUTS; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (adv) begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= ctl3_reg;
            if (ctl4_reg.valid) begin
                acc_reg <= acc_next;
                sat_reg <= sat_next;
            end
        end
    end

    // Result leaves on the last channel
    assign push = adv && ctl4_reg.valid && ctl4_reg.last;

    always_comb begin
        for (int k = 0; k < OUTS; k++) begin
            result.sums[k] = acc_next[k];
        end
        result.sat = sat_next;
    end

endmodule

`default_nettype wire

/* rtl/winograd_f2x2_3x3_tile_conv.sv */
// Winograd F(2x2,3x3) tile engine: one tile row accepted per cycle while s_tready is high.
// A row-3 last_channel request passes transform, product, y, o, output regs to m_tvalid.
// Throughput: 1 request per cycle; 16 multiplier lanes take a whole tile on its last row.
// Input stalls only while both the output register and the skid register hold results.
// Reset (aresetn low, synchronous): clears pipeline valids, accumulators and saturation flag.
`default_nettype none

`include "winograd_f2x2_3x3_tile_conv_assert.svh"

module winograd_f2x2_3x3_tile_conv (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // sample0, sample1, sample2, sample3, weight0, weight1, weight2
    input  wire  [wtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // row_index, first_channel
    input  wire  [wtc_pkg::S_TUSER_W-1:0]   s_tuser,
    // last_channel
    input  wire                             s_tlast,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out00, out01, out10, out11
    output logic [wtc_pkg::M_TDATA_W-1:0]   m_tdata,
    // saturated
    output logic                            m_tuser
);
    import wtc_pkg::*;

    logic             accept;
    logic             adv;
    logic [ROW_W-1:0] row;
    sample_t          s_row [TILE_N];
    weight_t          w_row [KER_N];

    sample_t tile_reg   [STORE_ROWS][TILE_N];
    weight_t kernel_reg [STORE_ROWS][KER_N];

    sample_t d  [TILE_N][TILE_N];
    rt_t     rt [TILE_N][TILE_N];
    kr_t     kr [TILE_N][KER_N];
    dt_t     dt_next [LANES];
    kt_t     kt_next [LANES];
    dt_t     dt_reg  [LANES];
    kt_t     kt_reg  [LANES];
    ctl_t    ctl1_next;
    ctl_t    ctl1_reg;
    ctl_t    ctl2_reg;
    prod_t   prod [LANES];

    logic    res_push;
    result_t res_data;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    // Request unpacking
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign row      = s_tuser[ROW_W-1:0];

    always_comb begin
        for (int j = 0; j < TILE_N; j++) begin
            s_row[j] = s_tdata[j*SAMPLE_W +: SAMPLE_W];
        end
        for (int j = 0; j < KER_N; j++) begin
            w_row[j] = s_tdata[TILE_N*SAMPLE_W + j*WEIGHT_W +: WEIGHT_W];
        end
    end

    // Rows 0..2 of tile and kernel are held until the last row arrives
    always_ff @(posedge aclk) begin
        if (accept && row != LAST_ROW) begin
            for (int j = 0; j < TILE_N; j++) begin
                tile_reg[row][j] <= s_row[j];
            end
            for (int j = 0; j < KER_N; j++) begin
                kernel_reg[row][j] <= w_row[j];
            end
        end
    end

    // Input transform B^T d B: columns first, then rows
    always_comb begin
        for (int i = 0; i < STORE_ROWS; i++) begin
            for (int j = 0; j < TILE_N; j++) begin
                d[i][j] = tile_reg[i][j];
            end
        end
        for (int j = 0; j < TILE_N; j++) begin
            d[TILE_N-1][j] = s_row[j];
        end
        for (int j = 0; j < TILE_N; j++) begin
            rt[0][j] = RT_W'(d[0][j]) - RT_W'(d[2][j]);
            rt[1][j] = RT_W'(d[1][j]) + RT_W'(d[2][j]);
            rt[2][j] = RT_W'(d[2][j]) - RT_W'(d[1][j]);
            rt[3][j] = RT_W'(d[1][j]) - RT_W'(d[3][j]);
        end
        for (int i = 0; i < TILE_N; i++) begin
            dt_next[i*TILE_N + 0] = DT_W'(rt[i][0]) - DT_W'(rt[i][2]);
            dt_next[i*TILE_N + 1] = DT_W'(rt[i][1]) + DT_W'(rt[i][2]);
            dt_next[i*TILE_N + 2] = DT_W'(rt[i][2]) - DT_W'(rt[i][1]);
            dt_next[i*TILE_N + 3] = DT_W'(rt[i][1]) - DT_W'(rt[i][3]);
        end
    end

    // Kernel transform (2G) g (2G)^T, integer at scale 4
    always_comb begin
        for (int j = 0; j < KER_N; j++) begin
            kr[0][j] = KR_W'(kernel_reg[0][j]) + KR_W'(kernel_reg[0][j]);
            kr[1][j] = KR_W'(kernel_reg[0][j]) + KR_W'(kernel_reg[1][j])
                     + KR_W'(kernel_reg[2][j]);
            kr[2][j] = KR_W'(kernel_reg[0][j]) - KR_W'(kernel_reg[1][j])
                     + KR_W'(kernel_reg[2][j]);
            kr[3][j] = KR_W'(kernel_reg[2][j]) + KR_W'(kernel_reg[2][j]);
        end
        for (int i = 0; i < TILE_N; i++) begin
            kt_next[i*TILE_N + 0] = KT_W'(kr[i][0]) + KT_W'(kr[i][0]);
            kt_next[i*TILE_N + 1] = KT_W'(kr[i][0]) + KT_W'(kr[i][1]) + KT_W'(kr[i][2]);
            kt_next[i*TILE_N + 2] = KT_W'(kr[i][0]) - KT_W'(kr[i][1]) + KT_W'(kr[i][2]);
            kt_next[i*TILE_N + 3] = KT_W'(kr[i][2]) + KT_W'(kr[i][2]);
        end
    end

    assign ctl1_next.valid = accept && row == LAST_ROW;
    assign ctl1_next.first = s_tuser[ROW_W];
    assign ctl1_next.last  = s_tlast;

    // Transform registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            dt_reg <= dt_next;
            kt_reg <= kt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Sixteen multiplier lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        wtc_lane u_lane (
            .aclk (aclk),
            .adv  (adv),
            .dt   (dt_reg[g]),
            .kt   (kt_reg[g]),
            .prod (prod[g])
        );
    end

    // Output transform and channel accumulation
    wtc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .prod    (prod),
        .ctl_in  (ctl2_reg),
        .push    (res_push),
        .result  (res_data)
    );

    // Output register with skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (res_push) begin
                out_data_next = res_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (res_push) begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
            end
        end else if (res_push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg.sums);
    assign m_tuser  = out_data_reg.sat;

    // Checks
    `WTC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds a result while output register is empty")
    `WTC_ASSERT_IMP(a_no_push_when_full, aclk, aresetn, res_push, !skid_valid_reg, "result pushed while skid is full")
    `WTC_ASSERT_NXT(a_skid_drains, aclk, aresetn, out_valid_reg && m_tready && skid_valid_reg, out_valid_reg && !skid_valid_reg, "skid result not moved to output register")

endmodule

`default_nettype wire
